/* hw/rtl/vsx_pkg.sv */
// Shared types, character codes and key matching for the SVLEN extractor.
package vsx_pkg;

  localparam int LENGTH_BITS = 32;
  localparam int MAG_W = LENGTH_BITS - 1;
  localparam int PROD_W = MAG_W + 4;
  localparam int OUT_W = 32;
  localparam int POS_W = 31;

  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_SVLEN = 2'd1;
  localparam logic [1:0] SRC_END = 2'd2;

  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_KEY = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;
  localparam logic [1:0] PH_EXTRA = 2'd3;

  localparam logic [3:0] KEY_START = 4'd0;
  localparam logic [3:0] KEY_S = 4'd1;
  localparam logic [3:0] KEY_SV = 4'd2;
  localparam logic [3:0] KEY_SVL = 4'd3;
  localparam logic [3:0] KEY_SVLE = 4'd4;
  localparam logic [3:0] KEY_SVLEN = 4'd5;
  localparam logic [3:0] KEY_E = 4'd6;
  localparam logic [3:0] KEY_EN = 4'd7;
  localparam logic [3:0] KEY_END = 4'd8;
  localparam logic [3:0] KEY_DEAD = 4'd15;

  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_UP_S = 8'h53;
  localparam logic [7:0] CH_UP_V = 8'h56;
  localparam logic [7:0] CH_UP_L = 8'h4C;
  localparam logic [7:0] CH_UP_E = 8'h45;
  localparam logic [7:0] CH_UP_N = 8'h4E;
  localparam logic [7:0] CH_UP_D = 8'h44;

  typedef struct packed {
    logic [7:0] info_byte;
    logic [POS_W-1:0] pos_value;
    logic last_byte;
  } item_t;

  typedef struct packed {
    logic found;
    logic [OUT_W-1:0] length;
    logic [1:0] source;
  } result_t;

  function automatic logic [3:0] key_advance(input logic [3:0] k, input logic [7:0] b);
    logic [3:0] r;
    r = KEY_DEAD;
    case (k)
      KEY_START: r = (b == CH_UP_S) ? KEY_S : ((b == CH_UP_E) ? KEY_E : KEY_DEAD);
      KEY_S: r = (b == CH_UP_V) ? KEY_SV : KEY_DEAD;
      KEY_SV: r = (b == CH_UP_L) ? KEY_SVL : KEY_DEAD;
      KEY_SVL: r = (b == CH_UP_E) ? KEY_SVLE : KEY_DEAD;
      KEY_SVLE: r = (b == CH_UP_N) ? KEY_SVLEN : KEY_DEAD;
      KEY_E: r = (b == CH_UP_N) ? KEY_EN : KEY_DEAD;
      KEY_EN: r = (b == CH_UP_D) ? KEY_END : KEY_DEAD;
      default: r = KEY_DEAD;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/vsx_in_stage.sv */
// Input register stage that holds one accepted byte request for the parser.
module vsx_in_stage (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] in_info_byte,
  input  logic [vsx_pkg::POS_W-1:0] in_pos_value,
  input  logic in_last_byte,
  input  logic take,
  output logic hold_valid,
  output vsx_pkg::item_t hold_item
);

  logic valid_r;
  logic valid_nxt;
  vsx_pkg::item_t item_r;
  logic load;

  assign in_stall = valid_r && !take;
  assign load = in_valid && !in_stall;
  assign valid_nxt = load || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.info_byte <= in_info_byte;
      item_r.pos_value <= in_pos_value;
      item_r.last_byte <= in_last_byte;
    end
  end

  assign hold_valid = valid_r;
  assign hold_item = item_r;

endmodule

/* hw/rtl/vsx_core.sv */
// Token parser state and per-byte update logic for SVLEN and END keys.
module vsx_core (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  vsx_pkg::item_t item,
  output vsx_pkg::result_t res
);

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] key_r, key_nxt;
  logic eq_r, eq_nxt;
  logic [vsx_pkg::MAG_W-1:0] acc_r, acc_nxt;
  logic neg_r, neg_nxt;
  logic pres_r, pres_nxt;
  logic [vsx_pkg::MAG_W-1:0] best_r, best_nxt;
  logic [vsx_pkg::OUT_W-1:0] start_adj_r, start_adj_nxt;
  logic [1:0] dec_r, dec_nxt;
  logic [vsx_pkg::OUT_W-1:0] len_r, len_nxt;
  logic first_r, first_nxt;

  logic [1:0] t_phase;
  logic [3:0] t_key;
  logic t_eq;
  logic [vsx_pkg::MAG_W-1:0] t_acc;
  logic t_neg;
  logic t_pres;
  logic [vsx_pkg::MAG_W-1:0] t_best;
  logic [vsx_pkg::MAG_W-1:0] fin_best;
  logic [vsx_pkg::OUT_W-1:0] end_val;
  logic [1:0] dec_fin;
  logic [vsx_pkg::OUT_W-1:0] len_fin;
  logic [7:0] b;
  logic is_digit;
  logic [3:0] digit;
  logic [vsx_pkg::PROD_W-1:0] prod;
  logic [vsx_pkg::MAG_W-1:0] acc_sat;
  logic closes;

  assign b = item.info_byte;
  assign is_digit = (b >= vsx_pkg::CH_ZERO) && (b <= vsx_pkg::CH_NINE);
  assign digit = 4'(b - vsx_pkg::CH_ZERO);
  assign prod = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1)
              + vsx_pkg::PROD_W'(digit);
  assign acc_sat = (prod[vsx_pkg::PROD_W-1:vsx_pkg::MAG_W] != 4'd0)
                 ? {vsx_pkg::MAG_W{1'b1}} : prod[vsx_pkg::MAG_W-1:0];

  // Apply one byte to the current token.
  always_comb begin
    t_phase = phase_r;
    t_key = key_r;
    t_eq = eq_r;
    t_acc = acc_r;
    t_neg = neg_r;
    t_pres = pres_r;
    t_best = best_r;
    if (b != vsx_pkg::CH_SEMI) begin
      if (b == vsx_pkg::CH_EQ) begin
        t_eq = 1'b1;
      end else begin
        if (eq_r) begin
          t_eq = 1'b0;
          if (phase_r != vsx_pkg::PH_EXTRA) begin
            t_phase = phase_r + 2'd1;
          end
        end
        if (t_phase == vsx_pkg::PH_KEY) begin
          t_key = vsx_pkg::key_advance(key_r, b);
        end else if (t_phase == vsx_pkg::PH_VALUE) begin
          if (b == vsx_pkg::CH_COMMA && key_r == vsx_pkg::KEY_SVLEN) begin
            if (pres_r && acc_r > best_r) begin
              t_best = acc_r;
            end
            t_acc = '0;
            t_neg = 1'b0;
            t_pres = 1'b0;
          end else if (b != vsx_pkg::CH_COMMA) begin
            if (b == vsx_pkg::CH_MINUS && !pres_r) begin
              t_neg = 1'b1;
            end else if (is_digit) begin
              t_acc = acc_sat;
            end
            t_pres = 1'b1;
          end
        end
      end
    end
  end

  assign fin_best = (t_pres && t_acc > t_best) ? t_acc : t_best;
  assign end_val = (t_neg ? (vsx_pkg::OUT_W'(0) - vsx_pkg::OUT_W'(t_acc))
                          : vsx_pkg::OUT_W'(t_acc)) + start_adj_r;
  assign closes = (b == vsx_pkg::CH_SEMI) || item.last_byte;

  // Decide when a token closes with exactly key and value.
  always_comb begin
    dec_fin = dec_r;
    len_fin = len_r;
    if (dec_r == vsx_pkg::SRC_NONE && closes && t_phase == vsx_pkg::PH_VALUE) begin
      if (t_key == vsx_pkg::KEY_SVLEN) begin
        dec_fin = vsx_pkg::SRC_SVLEN;
        len_fin = vsx_pkg::OUT_W'(fin_best);
      end else if (t_key == vsx_pkg::KEY_END) begin
        dec_fin = vsx_pkg::SRC_END;
        len_fin = end_val;
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    key_nxt = key_r;
    eq_nxt = eq_r;
    acc_nxt = acc_r;
    neg_nxt = neg_r;
    pres_nxt = pres_r;
    best_nxt = best_r;
    start_adj_nxt = start_adj_r;
    dec_nxt = dec_r;
    len_nxt = len_r;
    first_nxt = first_r;
    if (step) begin
      if (first_r) begin
        start_adj_nxt = vsx_pkg::OUT_W'(1) - vsx_pkg::OUT_W'(item.pos_value);
        first_nxt = 1'b0;
      end
      if (dec_r == vsx_pkg::SRC_NONE) begin
        dec_nxt = dec_fin;
        len_nxt = len_fin;
        if (closes) begin
          phase_nxt = vsx_pkg::PH_NONE;
          key_nxt = vsx_pkg::KEY_START;
          eq_nxt = 1'b1;
          acc_nxt = '0;
          neg_nxt = 1'b0;
          pres_nxt = 1'b0;
          best_nxt = '0;
        end else begin
          phase_nxt = t_phase;
          key_nxt = t_key;
          eq_nxt = t_eq;
          acc_nxt = t_acc;
          neg_nxt = t_neg;
          pres_nxt = t_pres;
          best_nxt = t_best;
        end
      end
      if (item.last_byte) begin
        phase_nxt = vsx_pkg::PH_NONE;
        key_nxt = vsx_pkg::KEY_START;
        eq_nxt = 1'b1;
        acc_nxt = '0;
        neg_nxt = 1'b0;
        pres_nxt = 1'b0;
        best_nxt = '0;
        dec_nxt = vsx_pkg::SRC_NONE;
        len_nxt = '0;
        first_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= vsx_pkg::PH_NONE;
      key_r <= vsx_pkg::KEY_START;
      eq_r <= 1'b1;
      acc_r <= '0;
      neg_r <= 1'b0;
      pres_r <= 1'b0;
      best_r <= '0;
      start_adj_r <= vsx_pkg::OUT_W'(1);
      dec_r <= vsx_pkg::SRC_NONE;
      len_r <= '0;
      first_r <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      key_r <= key_nxt;
      eq_r <= eq_nxt;
      acc_r <= acc_nxt;
      neg_r <= neg_nxt;
      pres_r <= pres_nxt;
      best_r <= best_nxt;
      start_adj_r <= start_adj_nxt;
      dec_r <= dec_nxt;
      len_r <= len_nxt;
      first_r <= first_nxt;
    end
  end

  assign res.found = (dec_fin != vsx_pkg::SRC_NONE);
  assign res.length = (dec_fin != vsx_pkg::SRC_NONE) ? len_fin : '0;
  assign res.source = dec_fin;

endmodule

/* hw/rtl/vsx_out_stage.sv */
// Result register that holds one result request until the consumer takes it.
module vsx_out_stage (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  vsx_pkg::result_t res,
  output logic free,
  output logic out_valid,
  input  logic out_stall,
  output logic out_found,
  output logic [vsx_pkg::OUT_W-1:0] out_length,
  output logic [1:0] out_source
);

  logic valid_r;
  logic valid_nxt;
  vsx_pkg::result_t res_r;

  assign free = !valid_r || !out_stall;
  assign valid_nxt = load || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_found = res_r.found;
  assign out_length = res_r.length;
  assign out_source = res_r.source;

endmodule

/* hw/rtl/vcf_svlen_extractor.sv */
// Top level of the VCF INFO SVLEN/END length extractor.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_stall  in_info_byte, in_pos_value, in_last_byte
//   out_     output     out_valid / out_stall out_found, out_length, out_source
//
// One byte request is accepted per cycle while in_stall is low, and it is parsed from the input register.
// A result request appears on out_ in the cycle after the last byte is parsed.
// The per-byte token state in the parser sets the one-byte-per-cycle rate while no result is stalled.
// Reset is synchronous and active low; it clears the parser and both stages.
// A stalled result blocks only the parsing of a further last byte.
module vcf_svlen_extractor (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] in_info_byte,
  input  logic [vsx_pkg::POS_W-1:0] in_pos_value,
  input  logic in_last_byte,
  output logic out_valid,
  input  logic out_stall,
  output logic out_found,
  output logic signed [vsx_pkg::OUT_W-1:0] out_length,
  output logic [1:0] out_source
);

  logic hold_valid;
  vsx_pkg::item_t hold_item;
  logic take;
  logic out_free;
  logic out_load;
  vsx_pkg::result_t res;

  assign take = hold_valid && (!hold_item.last_byte || out_free);
  assign out_load = take && hold_item.last_byte;

  vsx_in_stage u_in (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_info_byte(in_info_byte),
    .in_pos_value(in_pos_value),
    .in_last_byte(in_last_byte),
    .take(take),
    .hold_valid(hold_valid),
    .hold_item(hold_item)
  );

  vsx_core u_core (
    .clk(clk),
    .rst_n(rst_n),
    .step(take),
    .item(hold_item),
    .res(res)
  );

  vsx_out_stage u_out (
    .clk(clk),
    .rst_n(rst_n),
    .load(out_load),
    .res(res),
    .free(out_free),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_found(out_found),
    .out_length(out_length),
    .out_source(out_source)
  );

  a_found_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_found == (out_source != vsx_pkg::SRC_NONE)))
    else $error("found flag disagrees with source");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_length == '0))
    else $error("length not zero when nothing was found");

  a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_valid && !take) |=> hold_valid)
    else $error("held byte lost without being parsed");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result loaded over a pending result");

endmodule
